### rtl/pcft_pkg.sv
// Package for the point-in-cone-frustum test pipeline.
// Types, register indexes and stage count shared by rtl modules; no dependencies.
package pcft_pkg;

  localparam int NUM_STAGES = 8;

  typedef enum logic [2:0] {
    CFG_END_A_X   = 3'd0,
    CFG_END_A_Y   = 3'd1,
    CFG_END_A_Z   = 3'd2,
    CFG_END_B_X   = 3'd3,
    CFG_END_B_Y   = 3'd4,
    CFG_END_B_Z   = 3'd5,
    CFG_RADIUS_A  = 3'd6,
    CFG_RADIUS_B  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] end_a_x;
    logic signed [15:0] end_a_y;
    logic signed [15:0] end_a_z;
    logic signed [15:0] end_b_x;
    logic signed [15:0] end_b_y;
    logic signed [15:0] end_b_z;
    logic        [14:0] radius_at_a;
    logic        [14:0] radius_at_b;
  } cfg_t;

  // axis length squared, projection and cross product
  typedef struct packed {
    logic        [33:0] len2;
    logic signed [34:0] proj;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
  } geom_t;

  // partial products of both sides of the radial compare
  typedef struct packed {
    logic [67:0] lhs_lo;
    logic [67:0] lhs_hi;
    logic [51:0] rhs_ll;
    logic [50:0] rhs_lh;
    logic [49:0] rhs_hh;
    logic        range_ok;
  } part_t;

endpackage

### rtl/pcft_pt_if.sv
// Point channel: valid/ready handshake carrying one 3-D point.
// Standalone interface; no dependencies.
interface pcft_pt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

### rtl/pcft_res_if.sv
// Result channel: valid/ready handshake carrying the inside flag.
// Standalone interface; no dependencies.
interface pcft_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

### rtl/point_in_cone_frustum_test.sv
// Top level of the point-in-cone-frustum test: config registers and 8-stage pipeline.
// Depends on pcft_pkg, pcft_pt_if, pcft_res_if, pcft_ctl, pcft_front, pcft_mid, pcft_back.
//
//   port     dir   kind              contents
//   in_pt    in    valid/ready       point_x, point_y, point_z (16b signed)
//   out_res  out   valid/ready       inside_res (1b)
//   cfg_*    in    write-only regs   cfg_we, cfg_idx (3b), cfg_wdata (16b)
//
// One point per cycle is taken; a full pipeline with out_res.ready low stalls intake.
// Stage depth is set by the 34x34 partial products of the radial compare.
// Synchronous active-low reset clears valid bits and config registers.
// Each stage holds while its successor is full and stalled; bubbles collapse.
module point_in_cone_frustum_test
  import pcft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pcft_pt_if.sink     in_pt,
  pcft_res_if.source  out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  cfg_t                  cfg_r;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] vld;
  geom_t                 geom;
  part_t                 part;
  logic                  inside_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_END_A_X:  cfg_r.end_a_x     <= cfg_wdata;
        CFG_END_A_Y:  cfg_r.end_a_y     <= cfg_wdata;
        CFG_END_A_Z:  cfg_r.end_a_z     <= cfg_wdata;
        CFG_END_B_X:  cfg_r.end_b_x     <= cfg_wdata;
        CFG_END_B_Y:  cfg_r.end_b_y     <= cfg_wdata;
        CFG_END_B_Z:  cfg_r.end_b_z     <= cfg_wdata;
        CFG_RADIUS_A: cfg_r.radius_at_a <= cfg_wdata[14:0];
        CFG_RADIUS_B: cfg_r.radius_at_b <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  pcft_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .out_ready (out_res.ready),
    .en        (en),
    .vld       (vld)
  );

  pcft_front u_front (
    .clk     (clk),
    .en      (en[2:0]),
    .cfg     (cfg_r),
    .point_x (in_pt.point_x),
    .point_y (in_pt.point_y),
    .point_z (in_pt.point_z),
    .geom    (geom)
  );

  pcft_mid u_mid (
    .clk  (clk),
    .en   (en[5:3]),
    .cfg  (cfg_r),
    .geom (geom),
    .part (part)
  );

  pcft_back u_back (
    .clk         (clk),
    .en          (en[7:6]),
    .part        (part),
    .inside_flag (inside_flag)
  );

  assign in_pt.ready        = en[0];
  assign out_res.valid      = vld[NUM_STAGES-1];
  assign out_res.inside_res = inside_flag;

  // degenerate axis never reports inside
  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.inside_res |->
      (cfg_r.end_a_x != cfg_r.end_b_x) || (cfg_r.end_a_y != cfg_r.end_b_y) ||
      (cfg_r.end_a_z != cfg_r.end_b_z))
    else $error("inside reported for zero-length axis");

  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_pt.valid && in_pt.ready |=> vld[0])
    else $error("accepted transaction not captured in first stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NUM_STAGES-1] && !out_res.ready |=> vld[NUM_STAGES-1] && $stable(inside_flag))
    else $error("stalled result lost or changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_res.valid)
    else $error("result valid right after reset");

endmodule

### rtl/pcft_ctl.sv
// Pipeline control: per-stage valid bits and load enables with backpressure.
// Depends on pcft_pkg.
module pcft_ctl
  import pcft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output logic [NUM_STAGES-1:0] en,
  output logic [NUM_STAGES-1:0] vld
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign vld = vld_r;

endmodule

### rtl/pcft_front.sv
// Stages 1-3: offsets from end A, pairwise products, then length, projection
// and cross product sums. Depends on pcft_pkg.
module pcft_front
  import pcft_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         en,
  input  cfg_t               cfg,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  output geom_t              geom
);

  // stage 1
  logic signed [16:0] p_r [3];
  logic signed [16:0] d_r [3];
  // stage 2
  logic signed [33:0] dd_r [3];
  logic signed [33:0] pd_r [3];
  logic signed [33:0] x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;
  // stage 3
  geom_t geom_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= 17'(point_x) - 17'(cfg.end_a_x);
      p_r[1] <= 17'(point_y) - 17'(cfg.end_a_y);
      p_r[2] <= 17'(point_z) - 17'(cfg.end_a_z);
      d_r[0] <= 17'(cfg.end_b_x) - 17'(cfg.end_a_x);
      d_r[1] <= 17'(cfg.end_b_y) - 17'(cfg.end_a_y);
      d_r[2] <= 17'(cfg.end_b_z) - 17'(cfg.end_a_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        dd_r[k] <= d_r[k] * d_r[k];
        pd_r[k] <= p_r[k] * d_r[k];
      end
      x1_r <= p_r[1] * d_r[2];
      x2_r <= p_r[2] * d_r[1];
      y1_r <= p_r[2] * d_r[0];
      y2_r <= p_r[0] * d_r[2];
      z1_r <= p_r[0] * d_r[1];
      z2_r <= p_r[1] * d_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      geom_r.len2 <= 34'(dd_r[0]) + 34'(dd_r[1]) + 34'(dd_r[2]);
      geom_r.proj <= 35'(pd_r[0]) + 35'(pd_r[1]) + 35'(pd_r[2]);
      geom_r.cx   <= 34'(35'(x1_r) - 35'(x2_r));
      geom_r.cy   <= 34'(35'(y1_r) - 35'(y2_r));
      geom_r.cz   <= 34'(35'(z1_r) - 35'(z2_r));
    end
  end

  assign geom = geom_r;

endmodule

### rtl/pcft_mid.sv
// Stages 4-6: squared cross magnitudes, interpolated radius, and split
// partial products of both radial-test sides. Depends on pcft_pkg.
module pcft_mid
  import pcft_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] en,
  input  cfg_t       cfg,
  input  geom_t      geom,
  output part_t      part
);

  logic        [32:0] cm [3];
  logic signed [15:0] drad;

  // stage 4
  logic        [65:0] sq_r [3];
  logic        [48:0] rl_r;
  logic signed [50:0] rp_r;
  logic        [33:0] len2_4_r;
  logic               ok_4_r;
  // stage 5
  logic        [67:0] sumc_r;
  logic        [50:0] radm_r;
  logic        [33:0] len2_5_r;
  logic               ok_5_r;
  logic signed [51:0] rad;
  // stage 6
  part_t part_r;

  always_comb begin
    cm[0] = geom.cx[33] ? 33'(-geom.cx) : geom.cx[32:0];
    cm[1] = geom.cy[33] ? 33'(-geom.cy) : geom.cy[32:0];
    cm[2] = geom.cz[33] ? 33'(-geom.cz) : geom.cz[32:0];
    drad  = $signed({1'b0, cfg.radius_at_b}) - $signed({1'b0, cfg.radius_at_a});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= cm[k] * cm[k];
      end
      rl_r     <= cfg.radius_at_a * geom.len2;
      rp_r     <= drad * geom.proj;
      len2_4_r <= geom.len2;
      ok_4_r   <= (geom.len2 != '0) && !geom.proj[34] &&
                  ($signed({1'b0, geom.len2}) - 36'(geom.proj) >= 36'sd0);
    end
  end

  assign rad = $signed({3'b000, rl_r}) + 52'(rp_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sumc_r   <= 68'(sq_r[0]) + 68'(sq_r[1]) + 68'(sq_r[2]);
      radm_r   <= rad[51] ? 51'(-rad) : rad[50:0];
      len2_5_r <= len2_4_r;
      ok_5_r   <= ok_4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      part_r.lhs_lo   <= sumc_r[33:0] * len2_5_r;
      part_r.lhs_hi   <= sumc_r[67:34] * len2_5_r;
      part_r.rhs_ll   <= radm_r[25:0] * radm_r[25:0];
      part_r.rhs_lh   <= radm_r[25:0] * radm_r[50:26];
      part_r.rhs_hh   <= radm_r[50:26] * radm_r[50:26];
      part_r.range_ok <= ok_5_r;
    end
  end

  assign part = part_r;

endmodule

### rtl/pcft_back.sv
// Stages 7-8: recombine partial products and compare the radial test.
// Depends on pcft_pkg.
module pcft_back
  import pcft_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  part_t      part,
  output logic       inside_flag
);

  logic [103:0] lhs_r;
  logic [103:0] rhs_r;
  logic         ok_r;
  logic         inside_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lhs_r <= 104'(part.lhs_lo) + {2'b00, part.lhs_hi, 34'd0};
      rhs_r <= 104'(part.rhs_ll) + {26'd0, part.rhs_lh, 27'd0} +
               {2'b00, part.rhs_hh, 52'd0};
      ok_r  <= part.range_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      inside_r <= ok_r && (lhs_r <= rhs_r);
    end
  end

  assign inside_flag = inside_r;

endmodule
